FILE: src/alu_execute_unit_core_assert.svh
// ----------------------------------------------------------------------------
// ALU execute unit assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALU_EXECUTE_UNIT_CORE_ASSERT_SVH
`define ALU_EXECUTE_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define AEU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("aeu assertion failed");
`define AEU_NEVER(label, clk, rst_n, cond) \
	`AEU_ASSERT(label, clk, rst_n, !(cond))
`else
`define AEU_ASSERT(label, clk, rst_n, prop)
`define AEU_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: src/aeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU execute unit package
// Operation codes, pipeline payload types and divider sizing.
// ----------------------------------------------------------------------------
package aeu_pkg;

	localparam int DATA_W     = 16;
	localparam int DIV_BITS   = 16;
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEPS  = DIV_BITS / DIV_STAGES;

	typedef enum logic [3:0] {
		OP_SET  = 4'd0,
		OP_ADD  = 4'd1,
		OP_SUB  = 4'd2,
		OP_MUL  = 4'd3,
		OP_DIV  = 4'd4,
		OP_MOD  = 4'd5,
		OP_AND  = 4'd6,
		OP_OR   = 4'd7,
		OP_XOR  = 4'd8,
		OP_SHF  = 4'd9,
		OP_ROT  = 4'd10,
		OP_NEG  = 4'd11,
		OP_CMP  = 4'd12,
		OP_BSET = 4'd13,
		OP_BCLR = 4'd14,
		OP_BFLP = 4'd15
	} op_t;

	// Result of every operation except a real divide/modulo.
	typedef struct packed {
		logic [15:0] r;      // value for the destination
		logic [15:0] fv;     // value the flags are taken from
		logic        wr;
		logic        c;
		logic        cw;
		logic        fw;
		logic        is_div; // final value comes from the divider
	} front_res_t;

	// Restoring divider working set.
	typedef struct packed {
		logic [16:0] rem;
		logic [15:0] qd;     // dividend bits in, quotient bits out
		logic [16:0] dvs;
		logic        neg_q;
		logic        neg_r;
		logic        is_mod;
	} div_t;

endpackage

FILE: src/aeu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU execute unit channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface aeu_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         mode;
	logic signed [15:0] first_operand;
	logic signed [15:0] second_register;
	logic signed [15:0] immediate;

	modport source(output valid, mode, first_operand, second_register, immediate,
		input ready);
	modport sink(input valid, mode, first_operand, second_register, immediate,
		output ready);
endinterface

interface aeu_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] result_value;
	logic               write_result;
	logic               carry_flag;
	logic               carry_written;
	logic               equals_flag;
	logic               less_flag;
	logic               greater_flag;
	logic               flags_written;

	modport source(output valid, result_value, write_result, carry_flag, carry_written,
		equals_flag, less_flag, greater_flag, flags_written, input ready);
	modport sink(input valid, result_value, write_result, carry_flag, carry_written,
		equals_flag, less_flag, greater_flag, flags_written, output ready);
endinterface

FILE: src/aeu_op_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU execute unit operation stage
// Computes all non-divide results and sets up the divider operands.
// ----------------------------------------------------------------------------
module aeu_op_unit (
	input  logic [3:0]         mode,
	input  logic signed [15:0] a,
	input  logic signed [16:0] s,
	output aeu_pkg::front_res_t res,
	output aeu_pkg::div_t      div
);

	logic [17:0] sum18;
	logic [17:0] diff18;
	logic [17:0] neg18;
	logic signed [32:0] prod;
	logic [15:0] n16;
	logic [15:0] mag16;
	logic [4:0]  sh5;
	logic        sh_big;
	logic [16:0] lw;
	logic [16:0] rw;
	logic [16:0] smag;
	logic [3:0]  rk;
	logic [3:0]  rkr;
	logic [31:0] rdd;
	logic [15:0] rot;
	logic        bidx_ok;
	logic [15:0] bmask;
	logic [15:0] amag;

	always_comb begin
		sum18  = {{2{a[15]}}, a} + {s[16], s};
		diff18 = {{2{a[15]}}, a} - {s[16], s};
		neg18  = 18'd0 - {{2{a[15]}}, a};
		prod   = a * s;

		// shift amount: low half of the operand as signed
		n16    = s[15:0];
		mag16  = n16[15] ? (16'd0 - n16) : n16;
		sh_big = (mag16 > 16'd16);
		sh5    = mag16[4:0];
		lw     = {1'b0, a} << sh5;
		rw     = {a, 1'b0} >> sh5;

		// rotate amount: remainder of the full operand, sign kept
		smag = s[16] ? (17'd0 - s) : s;
		rk   = smag[3:0];
		rkr  = s[16] ? 4'(5'd16 - {1'b0, rk}) : rk;
		rdd  = {a, a} >> rkr;
		rot  = rdd[15:0];

		bidx_ok = (s[15:4] == 12'd0);
		bmask   = 16'd1 << s[3:0];

		amag = a[15] ? (16'd0 - a) : a;

		res        = '0;
		res.r      = a;
		res.wr     = 1'b1;
		div        = '0;
		div.qd     = amag;
		div.dvs    = smag;
		div.neg_q  = a[15] ^ s[16];
		div.neg_r  = a[15];
		div.is_mod = (aeu_pkg::op_t'(mode) == aeu_pkg::OP_MOD);

		unique case (aeu_pkg::op_t'(mode))
			aeu_pkg::OP_SET: begin
				res.r = s[15:0];
			end
			aeu_pkg::OP_ADD: begin
				res.r  = sum18[15:0];
				res.c  = sum18[16];
				res.cw = 1'b1;
				res.fw = 1'b1;
			end
			aeu_pkg::OP_SUB: begin
				res.r  = diff18[15:0];
				res.c  = diff18[16];
				res.cw = 1'b1;
				res.fw = 1'b1;
			end
			aeu_pkg::OP_MUL: begin
				res.r  = prod[15:0];
				res.c  = prod[16];
				res.cw = 1'b1;
				res.fw = 1'b1;
			end
			aeu_pkg::OP_DIV, aeu_pkg::OP_MOD: begin
				if (s == 17'sd0) begin
					res.wr = 1'b0;
				end else begin
					res.is_div = 1'b1;
					res.fw     = 1'b1;
				end
			end
			aeu_pkg::OP_AND: begin
				res.r  = a & s[15:0];
				res.fw = 1'b1;
			end
			aeu_pkg::OP_OR: begin
				res.r  = a | s[15:0];
				res.fw = 1'b1;
			end
			aeu_pkg::OP_XOR: begin
				res.r  = a ^ s[15:0];
				res.fw = 1'b1;
			end
			aeu_pkg::OP_SHF: begin
				res.fw = 1'b1;
				if (mag16 != 16'd0) begin
					res.cw = 1'b1;
					if (sh_big) begin
						res.r = 16'd0;
					end else if (n16[15]) begin
						res.r = lw[15:0];
						res.c = lw[16];
					end else begin
						res.r = rw[16:1];
						res.c = rw[0];
					end
				end
			end
			aeu_pkg::OP_ROT: begin
				res.fw = 1'b1;
				if (rk != 4'd0) begin
					res.r  = rot;
					res.cw = 1'b1;
					res.c  = s[16] ? rot[0] : rot[15];
				end
			end
			aeu_pkg::OP_NEG: begin
				res.r  = neg18[15:0];
				res.c  = neg18[16];
				res.cw = 1'b1;
				res.fw = 1'b1;
			end
			aeu_pkg::OP_CMP: begin
				res.wr = 1'b0;
				res.c  = diff18[16];
				res.cw = 1'b1;
				res.fw = 1'b1;
			end
			aeu_pkg::OP_BSET, aeu_pkg::OP_BCLR, aeu_pkg::OP_BFLP: begin
				if (!bidx_ok) begin
					res.wr = 1'b0;
				end else begin
					res.fw = 1'b1;
					if (aeu_pkg::op_t'(mode) == aeu_pkg::OP_BSET) begin
						res.r = a | bmask;
					end else if (aeu_pkg::op_t'(mode) == aeu_pkg::OP_BCLR) begin
						res.r = a & ~bmask;
					end else begin
						res.r = a ^ bmask;
					end
				end
			end
		endcase

		// compare takes its flags from the difference, all else from the result
		res.fv = (aeu_pkg::op_t'(mode) == aeu_pkg::OP_CMP) ? diff18[15:0] : res.r;
	end

endmodule

FILE: src/aeu_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU execute unit divider stage
// One register stage of the restoring divider: DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module aeu_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  aeu_pkg::front_res_t res_in,
	input  aeu_pkg::div_t       div_in,
	output logic                valid_out,
	output aeu_pkg::front_res_t res_out,
	output aeu_pkg::div_t       div_out
);

	aeu_pkg::div_t nxt;
	logic [17:0]   trial;
	logic [17:0]   shifted;

	always_comb begin
		nxt = div_in;
		for (int i = 0; i < aeu_pkg::DIV_STEPS; i++) begin
			shifted = {nxt.rem, nxt.qd[15]};
			trial   = shifted - {1'b0, nxt.dvs};
			if (!trial[17]) begin
				nxt.rem = trial[16:0];
				nxt.qd  = {nxt.qd[14:0], 1'b1};
			end else begin
				nxt.rem = shifted[16:0];
				nxt.qd  = {nxt.qd[14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_out <= res_in;
			div_out <= nxt;
		end
	end

endmodule

FILE: src/alu_execute_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU execute unit
// 16-bit ALU: arithmetic, logic, shift/rotate, divide, compare and bit ops.
// ----------------------------------------------------------------------------
// A word is accepted on every clock while the response side takes its words;
// each result is presented on the response side once it has passed seven
// register stages. The depth is set by the divider: 16 restoring steps spread
// over 4 register stages of 4 steps each, behind an operand stage and an
// operation stage, and followed by the output register. Every operation passes
// through the same stages, so results leave in request order. When the output
// word is held, the whole pipe freezes and req.ready drops in the same cycle.
// No reset sweep.
// ----------------------------------------------------------------------------
`include "alu_execute_unit_core_assert.svh"

module alu_execute_unit_core (
	input  logic             clk,
	input  logic             arst_n,
	aeu_in_if.sink           req,
	aeu_out_if.source        rsp
);

	// global advance: output register empty or being taken
	logic en;

	// s1: operands, second operand widened to its full 17-bit sum
	logic               valid_s1;
	logic [3:0]         mode_s1;
	logic signed [15:0] a_s1;
	logic signed [16:0] s_s1;

	// s2: operation results and divider setup
	aeu_pkg::front_res_t op_res;
	aeu_pkg::div_t       op_div;

	logic                valid_dv [aeu_pkg::DIV_STAGES+1];
	aeu_pkg::front_res_t res_dv   [aeu_pkg::DIV_STAGES+1];
	aeu_pkg::div_t       div_dv   [aeu_pkg::DIV_STAGES+1];

	// final selection feeding the output register
	aeu_pkg::front_res_t fin_res;
	aeu_pkg::div_t       fin_div;
	logic [15:0]         qv;
	logic [15:0]         rv;
	logic [15:0]         r_sel;
	logic [15:0]         fv_sel;
	logic                wr_sel;
	logic                fw_sel;

	// output register
	logic               valid_s7;
	logic signed [15:0] r_s7;
	logic               wr_s7;
	logic               c_s7;
	logic               cw_s7;
	logic               eq_s7;
	logic               lt_s7;
	logic               gt_s7;
	logic               fw_s7;

	assign en        = !valid_s7 || rsp.ready;
	assign req.ready = en;

	// ---- stage 1: operand capture ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= req.mode;
			a_s1    <= req.first_operand;
			s_s1    <= 17'(req.second_register) + 17'(req.immediate);
		end
	end

	// ---- stage 2: operation unit ----
	aeu_op_unit u_op (
		.mode (mode_s1),
		.a    (a_s1),
		.s    (s_s1),
		.res  (op_res),
		.div  (op_div)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_dv[0] <= 1'b0;
		end else if (en) begin
			valid_dv[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_dv[0] <= op_res;
			div_dv[0] <= op_div;
		end
	end

	// ---- stages 3..6: divider, other results ride along ----
	for (genvar g = 0; g < aeu_pkg::DIV_STAGES; g++) begin : g_div
		aeu_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_dv[g]),
			.res_in    (res_dv[g]),
			.div_in    (div_dv[g]),
			.valid_out (valid_dv[g+1]),
			.res_out   (res_dv[g+1]),
			.div_out   (div_dv[g+1])
		);
	end

	// ---- stage 7: sign fixup, flag generation, output register ----
	always_comb begin
		fin_res = res_dv[aeu_pkg::DIV_STAGES];
		fin_div = div_dv[aeu_pkg::DIV_STAGES];
		// truncating division: quotient sign from both, remainder from dividend
		qv = fin_div.neg_q ? (16'd0 - fin_div.qd) : fin_div.qd;
		rv = fin_div.neg_r ? (16'd0 - fin_div.rem[15:0]) : fin_div.rem[15:0];
		if (fin_res.is_div) begin
			r_sel  = fin_div.is_mod ? rv : qv;
			fv_sel = r_sel;
			wr_sel = 1'b1;
			fw_sel = 1'b1;
		end else begin
			r_sel  = fin_res.r;
			fv_sel = fin_res.fv;
			wr_sel = fin_res.wr;
			fw_sel = fin_res.fw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_dv[aeu_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s7  <= r_sel;
			wr_s7 <= wr_sel;
			c_s7  <= fin_res.cw && fin_res.c && !fin_res.is_div;
			cw_s7 <= fin_res.cw && !fin_res.is_div;
			eq_s7 <= fw_sel && (fv_sel == 16'd0);
			lt_s7 <= fw_sel && fv_sel[15];
			gt_s7 <= fw_sel && (fv_sel != 16'd0) && !fv_sel[15];
			fw_s7 <= fw_sel;
		end
	end

	assign rsp.valid         = valid_s7;
	assign rsp.result_value  = r_s7;
	assign rsp.write_result  = wr_s7;
	assign rsp.carry_flag    = c_s7;
	assign rsp.carry_written = cw_s7;
	assign rsp.equals_flag   = eq_s7;
	assign rsp.less_flag     = lt_s7;
	assign rsp.greater_flag  = gt_s7;
	assign rsp.flags_written = fw_s7;

	// ---- assertions ----
	// sign flags are mutually exclusive
	`AEU_ASSERT(a_flags_onehot, clk, arst_n, rsp.valid |-> $onehot0({eq_s7, lt_s7, gt_s7}))
	// unwritten flags read as zero
	`AEU_NEVER(a_flags_clear, clk, arst_n, rsp.valid && !fw_s7 && (eq_s7 || lt_s7 || gt_s7))
	// unwritten carry reads as zero
	`AEU_NEVER(a_carry_clear, clk, arst_n, rsp.valid && !cw_s7 && c_s7)
	// a word leaving the last divider stage lands in the output register
	`AEU_ASSERT(a_drain, clk, arst_n, en && valid_dv[aeu_pkg::DIV_STAGES] |=> valid_s7)

endmodule
